FILE: rtl/cba_pkg.sv
// Shared types, constants and codes of the contiguous block allocator.
// Depends on nothing; every other file imports it.
package cba_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int MAX_FILES  = 16;
    localparam int MAP_IDX_W  = $clog2(MAX_BLOCKS);

    localparam int MODE_W     = 1;
    localparam int FID_W      = 4;
    localparam int SIZE_W     = 16;
    localparam int START_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int BSIZE_W    = 8;
    localparam int NBLK_W     = 9;
    localparam int CFG_DATA_W = 9;

    // Rounded-up size fits one bit above the byte size.
    localparam int DIVIDEND_W = SIZE_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
    // Block address plus offset, wide enough to see past the end of the map.
    localparam int ADDR_W     = COUNT_W + 1;

    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RESET    = BSIZE_W'(10);
    localparam logic [NBLK_W-1:0]  BLOCKS_IN_USE_RESET = NBLK_W'(256);

    localparam logic MODE_CREATE = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_IN_USE    = 2'd3
    } status_e;

    typedef enum logic [0:0] {
        REG_BLOCK_SIZE    = 1'b0,
        REG_BLOCKS_IN_USE = 1'b1
    } cfg_index_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SCAN,
        S_MARK,
        S_FREE,
        S_REPORT,
        S_CLEAR
    } seq_state_e;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [FID_W-1:0]  file_id;
        logic [SIZE_W-1:0] size_bytes;
    } item_t;

    typedef struct packed {
        status_e            status;
        logic [START_W-1:0] start_block;
        logic [COUNT_W-1:0] block_count;
    } result_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [BSIZE_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/cba_divider.sv
// Restoring divider, one quotient bit per cycle, for rounding byte sizes to blocks.
// Depends on cba_pkg.
module cba_divider
    import cba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BSIZE_W-1:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [BSIZE_W-1:0]    dvsr_reg, dvsr_next;

    logic [BSIZE_W:0] trial;
    logic [BSIZE_W:0] diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign fits  = (trial >= {1'b0, dvsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            // The dividend shifts out the top while quotient bits enter at the bottom.
            rem_next = fits ? diff[BSIZE_W-1:0] : trial[BSIZE_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < dvsr_reg))
        else $error("divider remainder reached the divisor");

    a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");
`endif

endmodule

FILE: rtl/cba_seq.sv
// Sequencer of the allocator: free map, file extent table, scan, mark and free loops.
// Depends on cba_pkg; drives the divider through div_req_t / div_rsp_t.
module cba_seq
    import cba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  item_t              item,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [BSIZE_W-1:0] block_size,
    input  logic [NBLK_W-1:0]  blocks_in_use,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res,
    output div_req_t           div_req,
    input  div_rsp_t           div_rsp
);

    seq_state_e state_reg, state_next;

    logic                  mode_reg, mode_next;
    logic [FID_W-1:0]      id_reg, id_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [COUNT_W-1:0]    ctr_reg, ctr_next;
    logic [COUNT_W-1:0]    run_len_reg, run_len_next;
    logic [START_W-1:0]    run_start_reg, run_start_next;
    logic [COUNT_W-1:0]    best_len_reg, best_len_next;
    logic [START_W-1:0]    best_start_reg, best_start_next;
    logic [DIVIDEND_W-1:0] need_reg, need_next;
    result_t               res_reg, res_next;

    logic                  block_used_mem [MAX_BLOCKS];
    logic                  used_rd_reg;
    logic [MAX_FILES-1:0]  entry_valid_reg, entry_valid_next;
    logic [START_W-1:0]    entry_start_reg [MAX_FILES];
    logic [COUNT_W-1:0]    entry_blocks_reg [MAX_FILES];

    logic                  entry_we;
    logic                  map_we;
    logic                  map_wdata;
    logic [MAP_IDX_W-1:0]  map_raddr;
    logic [NBLK_W-1:0]     limit;
    logic [BSIZE_W-1:0]    divisor;
    logic [START_W-1:0]    base;
    logic [COUNT_W-1:0]    bound;
    logic [ADDR_W-1:0]     addr;
    logic                  addr_ok;
    logic                  more;
    logic                  cur_used;
    logic [COUNT_W-1:0]    run_len_inc;
    logic [START_W-1:0]    run_start_cur;

    assign limit   = (blocks_in_use > NBLK_W'(MAX_BLOCKS)) ? NBLK_W'(MAX_BLOCKS)
                                                           : blocks_in_use;
    assign divisor = (block_size == '0) ? BSIZE_W'(1) : block_size;

    // One address adder and one bound compare serve the clear, scan, mark and free loops.
    always_comb
    begin
        unique case (state_reg)
            S_FREE:
            begin
                base  = entry_start_reg[id_reg];
                bound = entry_blocks_reg[id_reg];
            end
            S_MARK:
            begin
                base  = best_start_reg;
                bound = need_reg[COUNT_W-1:0];
            end
            S_SCAN:
            begin
                base  = '0;
                bound = limit;
            end
            S_CLEAR:
            begin
                base  = '0;
                bound = COUNT_W'(MAX_BLOCKS);
            end
            default:
            begin
                base  = '0;
                bound = '0;
            end
        endcase
    end

    assign addr          = ADDR_W'(base) + ADDR_W'(ctr_reg);
    assign addr_ok       = (addr < ADDR_W'(MAX_BLOCKS));
    assign more          = (ctr_reg < bound);
    // The map is read at the next counter value, so the registered bit belongs to the current counter.
    assign map_raddr     = ctr_next[MAP_IDX_W-1:0];
    assign cur_used      = used_rd_reg;
    assign run_len_inc   = run_len_reg + COUNT_W'(1);
    assign run_start_cur = (run_len_reg == '0) ? addr[START_W-1:0] : run_start_reg;

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        id_next          = id_reg;
        size_next        = size_reg;
        ctr_next         = ctr_reg;
        run_len_next     = run_len_reg;
        run_start_next   = run_start_reg;
        best_len_next    = best_len_reg;
        best_start_next  = best_start_reg;
        need_next        = need_reg;
        res_next         = res_reg;
        entry_valid_next = entry_valid_reg;
        entry_we         = 1'b0;
        map_we           = 1'b0;
        map_wdata        = 1'b0;
        item_ready       = 1'b0;
        res_valid        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = DIVIDEND_W'(size_reg) + DIVIDEND_W'(divisor) - DIVIDEND_W'(1);
        div_req.divisor  = divisor;

        unique case (state_reg)
            S_CLEAR:
            begin
                if (more)
                begin
                    map_we    = 1'b1;
                    map_wdata = 1'b0;
                    ctr_next  = ctr_reg + COUNT_W'(1);
                end
                else
                begin
                    ctr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    mode_next  = item.mode;
                    id_next    = item.file_id;
                    size_next  = item.size_bytes;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctr_next = '0;
                if (mode_reg == MODE_DELETE)
                begin
                    if (!entry_valid_reg[id_reg])
                    begin
                        res_next   = '{status: ST_NOT_FOUND, start_block: '0, block_count: '0};
                        state_next = S_REPORT;
                    end
                    else
                    begin
                        state_next = S_FREE;
                    end
                end
                else if (entry_valid_reg[id_reg])
                begin
                    res_next   = '{status: ST_IN_USE, start_block: '0, block_count: '0};
                    state_next = S_REPORT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    need_next       = div_rsp.quotient;
                    ctr_next        = '0;
                    run_len_next    = '0;
                    run_start_next  = '0;
                    best_len_next   = '0;
                    best_start_next = '0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (more)
                begin
                    if (!cur_used)
                    begin
                        run_start_next = run_start_cur;
                        run_len_next   = run_len_inc;
                        // Strictly longer only, so the earliest run keeps a tie.
                        if (run_len_inc > best_len_reg)
                        begin
                            best_len_next   = run_len_inc;
                            best_start_next = run_start_cur;
                        end
                    end
                    else
                    begin
                        run_len_next = '0;
                    end
                    ctr_next = ctr_reg + COUNT_W'(1);
                end
                else if (DIVIDEND_W'(best_len_reg) < need_reg)
                begin
                    res_next   = '{status: ST_NO_SPACE, start_block: '0, block_count: '0};
                    state_next = S_REPORT;
                end
                else
                begin
                    ctr_next   = '0;
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                if (more)
                begin
                    if (addr_ok)
                    begin
                        map_we    = 1'b1;
                        map_wdata = 1'b1;
                    end
                    ctr_next = ctr_reg + COUNT_W'(1);
                end
                else
                begin
                    entry_we                 = 1'b1;
                    entry_valid_next[id_reg] = 1'b1;
                    res_next   = '{status: ST_OK, start_block: best_start_reg,
                                   block_count: need_reg[COUNT_W-1:0]};
                    state_next = S_REPORT;
                end
            end
            S_FREE:
            begin
                if (more)
                begin
                    if (addr_ok)
                    begin
                        map_we    = 1'b1;
                        map_wdata = 1'b0;
                    end
                    ctr_next = ctr_reg + COUNT_W'(1);
                end
                else
                begin
                    entry_valid_next[id_reg] = 1'b0;
                    res_next   = '{status: ST_OK, start_block: entry_start_reg[id_reg],
                                   block_count: entry_blocks_reg[id_reg]};
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            ctr_reg         <= '0;
            entry_valid_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            ctr_reg         <= ctr_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        size_reg       <= size_next;
        run_len_reg    <= run_len_next;
        run_start_reg  <= run_start_next;
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        need_reg       <= need_next;
        res_reg        <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            block_used_mem[addr[MAP_IDX_W-1:0]] <= map_wdata;
        end
        used_rd_reg <= block_used_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_start_reg[id_reg]  <= best_start_reg;
            entry_blocks_reg[id_reg] <= need_reg[COUNT_W-1:0];
        end
    end

    assign res = res_reg;

`ifndef NO_ASSERTIONS
    a_best_within_scanned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (best_len_reg <= ctr_reg))
        else $error("best run longer than the blocks scanned so far");

    a_mark_only_when_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> (need_reg <= DIVIDEND_W'(best_len_reg)))
        else $error("marking a run shorter than the request");

    a_create_ok_records: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_OK && mode_reg == MODE_CREATE)
            |-> entry_valid_reg[id_reg])
        else $error("successful create left its entry empty");

    a_delete_ok_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_OK && mode_reg == MODE_DELETE)
            |-> !entry_valid_reg[id_reg])
        else $error("successful delete left its entry valid");
`endif

endmodule

FILE: rtl/contiguous_block_allocator_top.sv
// Worst-fit contiguous block allocator: one item in flight at a time. After reset the block
// clears its free map, with item_ready low. A create runs the divider, scans the L managed
// blocks and marks the N blocks allocated; a create that finds no room ends after the scan; a
// delete frees its N recorded blocks; a create on a live id or a delete of an unknown id runs
// no loop. The scan, mark and free loops step one map block per cycle through a single
// address adder; the bit-serial divider (17 quotient bits, then a done strobe) rounds the
// byte size up to blocks. The result sits in an output register, so a new item is taken
// while the previous result waits. The user must write configuration through cfg_we /
// cfg_index / cfg_wdata only while the block is idle; the block itself does not enforce it.
// Top level: configuration registers and result register; uses cba_pkg, cba_seq, cba_divider.
module contiguous_block_allocator_top
    import cba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_we,
    input  cfg_index_e            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [BSIZE_W-1:0] block_size_reg;
    logic [NBLK_W-1:0]  blocks_in_use_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    logic     res_valid;
    logic     res_ready;
    result_t  res;
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg    <= BLOCK_SIZE_RESET;
            blocks_in_use_reg <= BLOCKS_IN_USE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLOCK_SIZE:    block_size_reg    <= cfg_wdata[BSIZE_W-1:0];
                REG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_wdata[NBLK_W-1:0];
                default:           block_size_reg    <= block_size_reg;
            endcase
        end
    end

    assign res_ready = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    cba_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .block_size    (block_size_reg),
        .blocks_in_use (blocks_in_use_reg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .div_req       (div_req),
        .div_rsp       (div_rsp)
    );

    cba_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for contiguous_block_allocator_top: directed table, then random phases.
// Depends on cba_pkg and the allocator RTL; holds its own worst-fit allocation predictor.
module testbench;
    import cba_pkg::*;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_e;

    typedef struct {
        row_kind_e             kind;
        item_t                 it;
        cfg_index_e            idx;
        logic [CFG_DATA_W-1:0] val;
        bit                    typed;
        result_t               res;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_we;
    cfg_index_e            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Predicted allocator state and configuration.
    bit                 block_taken [MAX_BLOCKS];
    bit                 file_live [MAX_FILES];
    int                 file_start [MAX_FILES];
    int                 file_blocks [MAX_FILES];
    logic [BSIZE_W-1:0] bsize_reg;
    logic [NBLK_W-1:0]  managed_reg;

    result_t awaited_results [$];
    row_t    script [$];
    int      mismatches = 0;
    bit      gaps_on;

    contiguous_block_allocator_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("contiguous_block_allocator_top regression: fail");
        $finish;
    end

    // Works out the result of one item and updates the predicted state.
    function automatic result_t allocator_outcome(item_t it);
        result_t r;
        int      fid;
        int      bs;
        int      need;
        int      lim;
        int      best_len;
        int      best_start;
        int      run_len;
        int      run_start;
        r = '0;
        r.status = ST_OK;
        fid = it.file_id;
        if (it.mode == MODE_DELETE)
        begin
            if (!file_live[fid])
                r.status = ST_NOT_FOUND;
            else
            begin
                for (int k = 0; k < file_blocks[fid]; k++)
                    if (file_start[fid] + k < MAX_BLOCKS)
                        block_taken[file_start[fid] + k] = 1'b0;
                file_live[fid] = 1'b0;
                r.start_block = START_W'(file_start[fid]);
                r.block_count = COUNT_W'(file_blocks[fid]);
            end
            return r;
        end
        if (file_live[fid])
        begin
            r.status = ST_IN_USE;
            return r;
        end
        bs = (bsize_reg == 0) ? 1 : int'(bsize_reg);
        need = (int'(it.size_bytes) + bs - 1) / bs;
        lim = (managed_reg > MAX_BLOCKS) ? MAX_BLOCKS : int'(managed_reg);
        best_len = 0;
        best_start = 0;
        run_len = 0;
        run_start = 0;
        for (int i = 0; i < lim; i++)
        begin
            if (!block_taken[i])
            begin
                if (run_len == 0)
                    run_start = i;
                run_len++;
                // Strictly longer only, so the earliest run keeps a tie.
                if (run_len > best_len)
                begin
                    best_len = run_len;
                    best_start = run_start;
                end
            end
            else
                run_len = 0;
        end
        if (best_len < need)
        begin
            r.status = ST_NO_SPACE;
            return r;
        end
        for (int k = 0; k < need; k++)
            if (best_start + k < MAX_BLOCKS)
                block_taken[best_start + k] = 1'b1;
        file_live[fid] = 1'b1;
        file_start[fid] = best_start;
        file_blocks[fid] = need;
        r.start_block = START_W'(best_start);
        r.block_count = COUNT_W'(need);
        return r;
    endfunction

    function automatic row_t step_row(logic mode, logic [FID_W-1:0] id,
                                      logic [SIZE_W-1:0] size);
        row_t r;
        r.kind = ROW_ITEM;
        r.it.mode = mode;
        r.it.file_id = id;
        r.it.size_bytes = size;
        r.idx = REG_BLOCK_SIZE;
        r.val = '0;
        r.typed = 1'b0;
        r.res = '0;
        return r;
    endfunction

    function automatic row_t checked_row(logic mode, logic [FID_W-1:0] id,
                                         logic [SIZE_W-1:0] size, status_e st,
                                         logic [START_W-1:0] sb, logic [COUNT_W-1:0] bc);
        row_t r;
        r = step_row(mode, id, size);
        r.typed = 1'b1;
        r.res.status = st;
        r.res.start_block = sb;
        r.res.block_count = bc;
        return r;
    endfunction

    function automatic row_t reg_row(cfg_index_e idx, logic [CFG_DATA_W-1:0] val);
        row_t r;
        r = step_row(MODE_CREATE, '0, '0);
        r.kind = ROW_CFG;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    // Appends one row to the end of the directed table.
    function automatic void add_row(row_t r);
        script.insert(script.size(), r);
    endfunction

    // Presents one item, holds it until accepted, then queues its expected result.
    task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
        result_t guess;
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        guess = allocator_outcome(it);
        awaited_results.insert(awaited_results.size(), typed ? typed_res : guess);
    endtask

    task automatic sender_gap();
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Registers are only written once every outstanding result has come back.
    task automatic write_reg(input cfg_index_e idx, input logic [CFG_DATA_W-1:0] val);
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BLOCK_SIZE)
            bsize_reg = val[BSIZE_W-1:0];
        else
            managed_reg = val;
    endtask

    initial
    begin
        result_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 19) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no result, actual status %0d start %0d count %0d",
                         $time, result.status, result.start_block, result.block_count);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result.status !== want.status || result.start_block !== want.start_block
                    || result.block_count !== want.block_count)
                begin
                    mismatches++;
                    $display("%0t: expected status %0d start %0d count %0d, actual %0d %0d %0d",
                             $time, want.status, want.start_block, want.block_count,
                             result.status, result.start_block, result.block_count);
                end
            end
        end
    end

    initial
    begin
        item_t                 it;
        int                    lim_now;
        int                    bs_now;
        int                    need;
        int                    size;
        int                    pick;
        int                    free_ids [$];
        int                    live_ids [$];
        logic [CFG_DATA_W-1:0] bs_w;
        logic [CFG_DATA_W-1:0] nb_w;

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = REG_BLOCK_SIZE;
        cfg_wdata = '0;
        gaps_on = 1'b1;
        bsize_reg = BLOCK_SIZE_RESET;
        managed_reg = BLOCKS_IN_USE_RESET;
        for (int i = 0; i < MAX_BLOCKS; i++)
            block_taken[i] = 1'b0;
        for (int f = 0; f < MAX_FILES; f++)
        begin
            file_live[f] = 1'b0;
            file_start[f] = 0;
            file_blocks[f] = 0;
        end

        // Default block size is 10 bytes over all 256 blocks.
        add_row(checked_row(MODE_DELETE, 4'd5, 16'd0, ST_NOT_FOUND, 8'd0, 9'd0));
        add_row(checked_row(MODE_CREATE, 4'd0, 16'd0, ST_OK, 8'd0, 9'd0));
        add_row(checked_row(MODE_CREATE, 4'd0, 16'd5, ST_IN_USE, 8'd0, 9'd0));
        add_row(checked_row(MODE_CREATE, 4'd1, 16'd1, ST_OK, 8'd0, 9'd1));
        add_row(checked_row(MODE_CREATE, 4'd2, 16'd10, ST_OK, 8'd1, 9'd1));
        add_row(checked_row(MODE_CREATE, 4'd3, 16'd11, ST_OK, 8'd2, 9'd2));
        add_row(checked_row(MODE_CREATE, 4'd4, 16'hFFFF, ST_NO_SPACE, 8'd0, 9'd0));
        add_row(checked_row(MODE_DELETE, 4'd2, 16'hFFFF, ST_OK, 8'd1, 9'd1));
        add_row(checked_row(MODE_DELETE, 4'd0, 16'd0, ST_OK, 8'd0, 9'd0));
        // The long run past the hole at block 1 wins.
        add_row(checked_row(MODE_CREATE, 4'd15, 16'd2520, ST_OK, 8'd4, 9'd252));
        add_row(checked_row(MODE_CREATE, 4'd14, 16'd11, ST_NO_SPACE, 8'd0, 9'd0));
        add_row(checked_row(MODE_CREATE, 4'd13, 16'd0, ST_OK, 8'd1, 9'd0));
        add_row(checked_row(MODE_CREATE, 4'd12, 16'd10, ST_OK, 8'd1, 9'd1));
        // Map is full now, so an empty file starts at block zero.
        add_row(checked_row(MODE_CREATE, 4'd11, 16'd0, ST_OK, 8'd0, 9'd0));
        add_row(checked_row(MODE_DELETE, 4'd15, 16'd0, ST_OK, 8'd4, 9'd252));
        // A block size of zero rounds like a block size of one.
        add_row(reg_row(REG_BLOCK_SIZE, 9'd0));
        add_row(step_row(MODE_CREATE, 4'd10, 16'd3));
        // Bit 8 of the write data falls outside the block size register.
        add_row(reg_row(REG_BLOCK_SIZE, 9'h1FF));
        add_row(checked_row(MODE_CREATE, 4'd9, 16'hFFFF, ST_NO_SPACE, 8'd0, 9'd0));
        add_row(step_row(MODE_CREATE, 4'd8, 16'd256));
        add_row(reg_row(REG_BLOCKS_IN_USE, 9'd0));
        add_row(checked_row(MODE_CREATE, 4'd7, 16'd1, ST_NO_SPACE, 8'd0, 9'd0));
        add_row(checked_row(MODE_CREATE, 4'd6, 16'd0, ST_OK, 8'd0, 9'd0));
        add_row(reg_row(REG_BLOCKS_IN_USE, 9'd511));
        add_row(step_row(MODE_CREATE, 4'd5, 16'd300));
        // Shrink the managed range under live files; deletes still free whole runs.
        add_row(reg_row(REG_BLOCKS_IN_USE, 9'd3));
        add_row(step_row(MODE_DELETE, 4'd10, 16'd0));
        add_row(step_row(MODE_CREATE, 4'd4, 16'd255));
        add_row(checked_row(MODE_DELETE, 4'd1, 16'd0, ST_OK, 8'd0, 9'd1));
        add_row(step_row(MODE_CREATE, 4'd4, 16'd255));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
                write_reg(script[i].idx, script[i].val);
            else
            begin
                send_item(script[i].it, script[i].typed, script[i].res);
                sender_gap();
            end
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            gaps_on = (ph % 4 != 1) && (ph != 9);
            case (ph)
                0:
                begin
                    bs_w = 9'd1;
                    nb_w = 9'd256;
                end
                1:
                begin
                    bs_w = 9'd255;
                    nb_w = 9'd1;
                end
                2:
                begin
                    bs_w = 9'h100;
                    nb_w = 9'd511;
                end
                default:
                begin
                    bs_w = CFG_DATA_W'($urandom_range(1, 511));
                    nb_w = (ph % 3 == 0) ? 9'd256 : CFG_DATA_W'($urandom_range(4, 48));
                end
            endcase
            write_reg(REG_BLOCK_SIZE, bs_w);
            write_reg(REG_BLOCKS_IN_USE, nb_w);
            lim_now = (managed_reg > MAX_BLOCKS) ? MAX_BLOCKS : int'(managed_reg);
            bs_now = (bsize_reg == 0) ? 1 : int'(bsize_reg);

            for (int n = 0; n < 70; n++)
            begin
                free_ids.delete();
                live_ids.delete();
                for (int f = 0; f < MAX_FILES; f++)
                    if (file_live[f])
                        live_ids.insert(live_ids.size(), f);
                    else
                        free_ids.insert(free_ids.size(), f);
                if ($urandom_range(0, 9) == 0)
                    it = item_t'($bits(item_t)'($urandom));
                else if (live_ids.size() == 0
                         || (free_ids.size() != 0 && $urandom_range(0, 99) < 55))
                begin
                    it.mode = MODE_CREATE;
                    it.file_id = FID_W'(free_ids[$urandom_range(0, free_ids.size() - 1)]);
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                        it.size_bytes = '0;
                    else if (pick < 16)
                        it.size_bytes = SIZE_W'($urandom);
                    else
                    begin
                        // Aim mostly at sizes that fit, sometimes just past the map.
                        need = (pick < 75) ? $urandom_range(1, lim_now / 3 + 1)
                                           : $urandom_range(1, lim_now + 2);
                        size = need * bs_now - $urandom_range(0, bs_now - 1);
                        it.size_bytes = (size > 65535) ? 16'hFFFF : SIZE_W'(size);
                    end
                end
                else
                begin
                    it.mode = MODE_DELETE;
                    it.file_id = FID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
                    it.size_bytes = SIZE_W'($urandom);
                end
                send_item(it, 1'b0, '0);
                sender_gap();
            end
        end

        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
        repeat (600) @(posedge clk);
        if (mismatches == 0)
            $display("contiguous_block_allocator_top regression: pass");
        else
            $display("contiguous_block_allocator_top regression: fail");
        $finish;
    end

endmodule
